// ===== design/meie_pkg.sv =====
package meie_pkg;

  // widths of the stream fields
  localparam int VALUE_W   = 32;
  localparam int MODULUS_W = 32;
  localparam int INVERSE_W = 32;
  localparam int IN_DATA_W = VALUE_W + MODULUS_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_OUT
  } state_t;

  // control from the sequencer to the division/MAC unit
  typedef struct packed {
    logic start;
  } step_ctrl_t;

  // status from the division/MAC unit back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } step_stat_t;

endpackage

// ===== design/meie_step.sv =====
// One Euclid step: restoring division of dividend by divisor, one quotient
// bit per cycle, MSB first. Each quotient bit also feeds a Horner-style
// shift-add of q * mult, so acc ends as (q * mult) mod 2^WIDTH.
module meie_step #(
  parameter int WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  meie_pkg::step_ctrl_t ctrl,
  output meie_pkg::step_stat_t stat,
  input  logic [WIDTH-1:0]    dividend,
  input  logic [WIDTH-1:0]    divisor,
  input  logic [WIDTH-1:0]    mult,
  output logic [WIDTH-1:0]    rem,
  output logic [WIDTH-1:0]    acc
);

  localparam int CNT_W = $clog2(WIDTH);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] dvd;

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             qbit;
  logic [WIDTH-1:0] rem_next;
  logic [WIDTH-1:0] acc_next;

  always_comb begin
    shifted  = {rem, dvd[WIDTH-1]};
    diff     = shifted - {1'b0, divisor};
    qbit     = (shifted >= {1'b0, divisor});
    rem_next = qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    acc_next = {acc[WIDTH-2:0], 1'b0} + (qbit ? mult : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WIDTH - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      dvd <= dividend;
      rem <= '0;
      acc <= '0;
    end else if (busy) begin
      dvd <= {dvd[WIDTH-2:0], 1'b0};
      rem <= rem_next;
      acc <= acc_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== design/modular_inverse_extended_euclid.sv =====
// Modular inverse by the extended Euclidean algorithm.
// Input stream: s_tdata carries value (bits 31:0) and modulus (bits 63:32);
// only the low WIDTH bits of each are used. Output stream: m_tdata is the
// inverse, m_tuser is the found flag (0 means no inverse, data then 0).
// One word is processed at a time: s_tready is high only while idle.
// Each Euclid step starts the shared division/MAC unit from ST_CHECK and
// waits for its done in ST_RUN; once the remainder is zero, ST_CHECK
// registers the result and ST_OUT raises m_tvalid. The result is held in an
// output register until m_tready; a stalled receiver simply keeps the block
// out of idle. Synchronous reset returns the block to idle with m_tvalid low.
module modular_inverse_extended_euclid #(
  parameter int WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [meie_pkg::IN_DATA_W-1:0]   s_tdata,   // value, modulus
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [meie_pkg::INVERSE_W-1:0]   m_tdata,   // inverse
  output logic                             m_tuser    // found
);

  meie_pkg::state_t state, state_next;

  logic [WIDTH-1:0] r;
  logic [WIDTH-1:0] rn;
  logic [WIDTH-1:0] tmag;
  logic [WIDTH-1:0] tnmag;
  logic             tneg;
  logic [WIDTH-1:0] mod;

  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] acc;

  meie_pkg::step_ctrl_t ctrl;
  meie_pkg::step_stat_t stat;

  logic [WIDTH-1:0] inv_w;
  logic             ok;
  logic [63:0]      inv_ext;

  meie_step #(
    .WIDTH(WIDTH)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .stat    (stat),
    .dividend(r),
    .divisor (rn),
    .mult    (tnmag),
    .rem     (rem),
    .acc     (acc)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      meie_pkg::ST_IDLE:  if (s_tvalid) state_next = meie_pkg::ST_CHECK;
      meie_pkg::ST_CHECK: state_next = (rn == '0) ? meie_pkg::ST_OUT : meie_pkg::ST_RUN;
      meie_pkg::ST_RUN:   if (stat.done) state_next = meie_pkg::ST_CHECK;
      meie_pkg::ST_OUT:   if (m_tready) state_next = meie_pkg::ST_IDLE;
      default:            state_next = meie_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    ctrl.start = 1'b0;
    case (state)
      meie_pkg::ST_IDLE:  s_tready = 1'b1;
      meie_pkg::ST_CHECK: ctrl.start = (rn != '0);
      meie_pkg::ST_OUT:   m_tvalid = 1'b1;
      default:            ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= meie_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // final result from the last remainder and coefficient
  always_comb begin
    ok    = (r <= WIDTH'(1));
    inv_w = '0;
    if (ok) begin
      inv_w = (tneg && tmag != '0) ? (mod - tmag) : tmag;
    end
    inv_ext = 64'(inv_w);
  end

  always_ff @(posedge clk) begin
    case (state)
      meie_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          rn    <= WIDTH'(s_tdata[meie_pkg::VALUE_W-1:0]);
          r     <= WIDTH'(s_tdata[meie_pkg::IN_DATA_W-1:meie_pkg::VALUE_W]);
          mod   <= WIDTH'(s_tdata[meie_pkg::IN_DATA_W-1:meie_pkg::VALUE_W]);
          tmag  <= '0;
          tnmag <= WIDTH'(1);
          tneg  <= 1'b1;
        end
      end
      meie_pkg::ST_CHECK: begin
        if (rn == '0) begin
          m_tdata <= inv_ext[meie_pkg::INVERSE_W-1:0];
          m_tuser <= ok;
        end
      end
      meie_pkg::ST_RUN: begin
        // coefficient signs alternate, so t - q*t_new is a magnitude sum
        if (stat.done) begin
          r     <= rn;
          rn    <= rem;
          tmag  <= tnmag;
          tnmag <= acc + tmag;
          tneg  <= ~tneg;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/meie_checker.sv =====
module meie_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [meie_pkg::INVERSE_W-1:0] m_tdata,
  input logic                           m_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // one word in flight: never ready for input while a result is offered
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while result pending");

  // an accepted word makes the block busy and gives no result at once
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready && !m_tvalid)
    else $error("block not busy after accepting a word");

  // no inverse means data zero
  a_zero_when_none: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("nonzero inverse without found");

  // delivered result returns the block to idle
  a_idle_after_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |=> s_tready && !m_tvalid)
    else $error("block not idle after result delivered");

endmodule

bind modular_inverse_extended_euclid meie_checker u_meie_checker (.*);

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W              = 32;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 1600;
  localparam int EXPECT_DEPTH   = 16;

  typedef struct packed {
    logic [meie_pkg::VALUE_W-1:0]   value;
    logic [meie_pkg::MODULUS_W-1:0] modulus;
    logic [meie_pkg::INVERSE_W-1:0] inverse;
    logic                           found;
  } inverse_entry_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [meie_pkg::IN_DATA_W-1:0] s_tdata = '0;  // value, modulus
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [meie_pkg::INVERSE_W-1:0] m_tdata;       // inverse
  logic                           m_tuser;       // found

  inverse_entry_t pending_inverses[EXPECT_DEPTH];
  int             wr_ptr       = 0;
  int             rd_ptr       = 0;
  int             errors       = 0;
  int             sender_idle  = 0;
  int             recv_stall   = 0;
  int             quiet_cycles = 0;

  modular_inverse_extended_euclid #(.WIDTH(W)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // extended Euclid with sign-magnitude coefficients, arithmetic mod 2^W
  function automatic inverse_entry_t predict_inverse(logic [31:0] value, logic [31:0] modulus);
    inverse_entry_t e;
    logic [W-1:0]   rem, rem_next, rem_new;
    logic [W-1:0]   coef, coef_next, coef_new, quot;
    logic           coef_neg;
    e.value    = value;
    e.modulus  = modulus;
    rem        = modulus[W-1:0];
    rem_next   = value[W-1:0];
    coef       = '0;
    coef_next  = W'(1);
    coef_neg   = 1'b1;
    while (rem_next != 0) begin
      quot      = rem / rem_next;
      coef_new  = coef + quot * coef_next;
      rem_new   = rem - quot * rem_next;
      coef      = coef_next;
      coef_next = coef_new;
      coef_neg  = !coef_neg;
      rem       = rem_next;
      rem_next  = rem_new;
    end
    e.inverse = '0;
    e.found   = 1'b0;
    if (rem <= 1) begin
      e.found = 1'b1;
      if (coef_neg && coef != 0) begin
        e.inverse = modulus[W-1:0] - coef;
      end else begin
        e.inverse = coef;
      end
    end
    return e;
  endfunction

  task automatic send_word(logic [31:0] value, logic [31:0] modulus);
    while ($urandom_range(99) < sender_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {modulus, value};
    do @(posedge clk); while (!s_tready);
    pending_inverses[wr_ptr % EXPECT_DEPTH] = predict_inverse(value, modulus);
    wr_ptr++;
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    inverse_entry_t exp_e;
    if (!rst && m_tvalid && m_tready) begin
      if (rd_ptr == wr_ptr) begin
        $display("%0t: unexpected word inverse %h found %0b", $time, m_tdata, m_tuser);
        errors++;
      end else begin
        exp_e = pending_inverses[rd_ptr % EXPECT_DEPTH];
        rd_ptr++;
        if (m_tdata !== exp_e.inverse) begin
          $display("%0t: inverse of %h mod %h: expected %h, actual %h",
                   $time, exp_e.value, exp_e.modulus, exp_e.inverse, m_tdata);
          errors++;
        end
        if (m_tuser !== exp_e.found) begin
          $display("%0t: found for %h mod %h: expected %0b, actual %0b",
                   $time, exp_e.value, exp_e.modulus, exp_e.found, m_tuser);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // zero value, moduli 0 and 1
  task automatic test_degenerate_moduli();
    send_word(32'd0, 32'd0);
    send_word(32'd0, 32'd1);
    send_word(32'd0, 32'd5);
    send_word(32'd1, 32'd0);
    send_word(32'd7, 32'd0);
    send_word(32'hFFFF_FFFF, 32'd0);
    send_word(32'd1, 32'd1);
    send_word(32'd9, 32'd1);
    send_word(32'hFFFF_FFFF, 32'd1);
  endtask

  task automatic test_textbook_cases();
    send_word(32'd3, 32'd11);
    send_word(32'd17, 32'd3120);
    send_word(32'd65537, 32'hC5A3_9E40);
    send_word(32'd10, 32'd4);          // common factor
    send_word(32'd6, 32'd9);
    send_word(32'd100, 32'd7);         // value above modulus
  endtask

  task automatic test_extremes();
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_word(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'd1, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFE, 32'hFFFF_FFFE);
    send_word(32'h8000_0000, 32'h7FFF_FFFF);
    // consecutive Fibonacci numbers: longest Euclid chain in 32 bits
    send_word(32'd1836311903, 32'd2971215073);
    send_word(32'd2971215073, 32'd1836311903);
  endtask

  task automatic test_random_operands(int count, int idle_pct, int stall_pct);
    logic [31:0] v, m, g;
    int          kind;
    sender_idle = idle_pct;
    recv_stall  = stall_pct;
    repeat (count) begin
      v    = $urandom;
      m    = $urandom;
      kind = $urandom_range(9);
      case (kind)
        4: begin
          case ($urandom_range(3))
            0: v = 32'd3;
            1: v = 32'd17;
            2: v = 32'd65537;
            default: v = v | 32'd1;
          endcase
          m = m & ~32'd1;
        end
        5: begin
          m = $urandom_range(2, 1 << 16);
        end
        6: begin
          v = $urandom_range(0, 255);
          m = $urandom_range(0, 255);
        end
        7: begin
          v = m - $urandom_range(0, 3);
        end
        8: begin
          g = $urandom_range(2, 1000);
          v = g * $urandom_range(1, 1 << 20);
          m = g * $urandom_range(1, 1 << 20);
        end
        9: begin
          m = $urandom_range(0, 1);
          if ($urandom_range(1)) v = $urandom_range(0, 1);
        end
        default: ;
      endcase
      send_word(v, m);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_degenerate_moduli();
    test_textbook_cases();
    test_extremes();
    test_random_operands(100, 0, 0);
    test_random_operands(100, 45, 0);
    test_random_operands(100, 0, 45);
    test_random_operands(100, 23, 23);
    s_tvalid <= 1'b0;
    while (rd_ptr != wr_ptr) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
